// File: design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types, constants and functions for the base64url decoder
// This package defines the stream payload structs, the group command that
// the front stage queues for the back stage, and the character classifier.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Default depth of the command queue between the front and back stages.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Classifier codes. A code below 64 is the sextet value of the symbol.
    localparam logic [6:0] CLS_SPACE   = 7'd64;
    localparam logic [6:0] CLS_INVALID = 7'd127;

    // Pending sextet counts; at COUNT_FULL the next symbol completes a group.
    localparam logic [1:0] COUNT_FULL  = 2'd3;
    localparam logic [1:0] COUNT_TWO   = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_text;
    } b64d_in_t;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        logic       error;
    } b64d_out_t;

    // One queued command: up to three results, the first byte in the top bits.
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  last_index;   // index of the final result, 0 to 2
        logic        byte_valid;
        logic        last;
        logic        error;
    } b64d_cmd_t;

    // Maps a character to its sextet value, CLS_SPACE or CLS_INVALID.
    function automatic logic [6:0] b64d_classify(input logic [7:0] c);
        logic [6:0] code;
        code = CLS_INVALID;
        if (c >= 8'd65 && c <= 8'd90) begin
            code = 7'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            code = 7'(c - 8'd97 + 8'd26);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            code = 7'(c - 8'd48 + 8'd52);
        end else if (c == 8'd45) begin
            code = 7'd62;
        end else if (c == 8'd95) begin
            code = 7'd63;
        end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
            code = CLS_SPACE;
        end
        return code;
    endfunction

endpackage

// File: design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: input stage of the base64url decoder
// Accepts one character per cycle while the queue has room, classifies it,
// gathers sextets and queues one command per group, flush or error.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  b64d_in_t   s_data,
    input  logic       q_full,
    output logic       q_push,
    output b64d_cmd_t  q_cmd
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  count_reg, count_next;
    logic        discard_reg, discard_next;

    logic        accept;
    logic [6:0]  cls;
    logic [23:0] full_group;

    // A new character is taken whenever the queue has room for its command.
    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign cls        = b64d_classify(s_data.symbol);
    assign full_group = {acc_reg, cls[5:0]};

    // Next state and command generation.
    always_comb begin
        acc_next     = acc_reg;
        count_next   = count_reg;
        discard_next = discard_reg;
        q_push       = 1'b0;
        q_cmd        = '0;
        if (accept) begin
            if (s_data.end_of_text) begin
                // End of text always leaves a clean state.
                acc_next     = '0;
                count_next   = '0;
                discard_next = 1'b0;
                if (!discard_reg) begin
                    q_push     = 1'b1;
                    q_cmd.last = 1'b1;
                    if (count_reg == COUNT_FULL) begin
                        q_cmd.bytes      = {acc_reg[17:2], 8'h00};
                        q_cmd.last_index = 2'd1;
                        q_cmd.byte_valid = 1'b1;
                    end else if (count_reg == COUNT_TWO) begin
                        q_cmd.bytes      = {acc_reg[11:4], 16'h0000};
                        q_cmd.byte_valid = 1'b1;
                    end
                end
            end else if (!discard_reg && cls != CLS_SPACE) begin
                if (cls == CLS_INVALID) begin
                    // Report once, then drop symbols until end of text.
                    acc_next     = '0;
                    count_next   = '0;
                    discard_next = 1'b1;
                    q_push       = 1'b1;
                    q_cmd.last   = 1'b1;
                    q_cmd.error  = 1'b1;
                end else if (count_reg == COUNT_FULL) begin
                    acc_next         = '0;
                    count_next       = '0;
                    q_push           = 1'b1;
                    q_cmd.bytes      = full_group;
                    q_cmd.last_index = 2'd2;
                    q_cmd.byte_valid = 1'b1;
                end else begin
                    acc_next   = full_group[17:0];
                    count_next = count_reg + 2'd1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            count_reg   <= '0;
            discard_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            count_reg   <= count_next;
            discard_reg <= discard_next;
        end
    end

endmodule

// File: design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue: command queue between the front and back stages
// A small circular buffer that decouples character intake from result output.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  b64d_cmd_t  push_cmd,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output b64d_cmd_t  pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_cmd_t          entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_cmd   = entries[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: output stage of the base64url decoder
// Takes commands from the queue and emits their results one per cycle, unless
// m_ready stalls the registered output stage.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  b64d_cmd_t  q_cmd,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output b64d_out_t  m_data
);

    b64d_cmd_t  cmd_reg, cmd_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    b64d_out_t  out_reg, out_next;

    logic       out_free;
    logic       emit;
    logic       final_emit;
    logic [7:0] sel_byte;

    assign out_free   = !out_valid_reg || m_ready;
    assign emit       = busy_reg && out_free;
    assign final_emit = emit && (idx_reg == cmd_reg.last_index);
    assign q_pop      = q_not_empty && (!busy_reg || final_emit);

    // Pick the byte of the current result, first byte in the top bits.
    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = cmd_reg.bytes[23:16];
            2'd1:    sel_byte = cmd_reg.bytes[15:8];
            2'd2:    sel_byte = cmd_reg.bytes[7:0];
            default: sel_byte = 8'h00;
        endcase
    end

    // Command sequencing and output register loading.
    always_comb begin
        cmd_next       = cmd_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free) begin
            out_valid_next = emit;
        end
        if (emit) begin
            out_next.data_byte  = sel_byte;
            out_next.byte_valid = cmd_reg.byte_valid;
            out_next.error      = cmd_reg.error;
            out_next.last       = cmd_reg.last && (idx_reg == cmd_reg.last_index);
            idx_next            = idx_reg + 2'd1;
        end
        if (final_emit) begin
            busy_next = 1'b0;
        end
        if (q_pop) begin
            cmd_next  = q_cmd;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: design/base64url_stream_decoder.sv
// Path: a character that produces results passes the command queue, the command
// register and the output register; its results leave one per cycle unless stalled.
// Throughput: one character per cycle while the command queue has room; the
// back stage emits one result per cycle while m_ready holds, so a full group
// of four symbols (three bytes) then never backs up the input.
// Reset: synchronous active-low aresetn clears the decoder state and queue.
// ----------------------------------------------------------------------------
// base64url_stream_decoder: unpadded base64url text to byte stream decoder
// A front stage classifies characters and builds group commands, a queue
// decouples it from a back stage that serializes the decoded bytes.
// ----------------------------------------------------------------------------
module base64url_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  b64d_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output b64d_out_t  m_data
);

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_not_empty;
    b64d_cmd_t  push_cmd;
    b64d_cmd_t  pop_cmd;

    // Character intake and grouping.
    b64d_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // Command queue between the two stages.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    // Result serialization.
    b64d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// File: design/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker: port-level assertions for the base64url decoder
// Watches the top-level ports and flags violations of input and output rules.
// ----------------------------------------------------------------------------
module b64d_checker
    import b64d_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input b64d_in_t   s_data,
    input logic       m_valid,
    input logic       m_ready,
    input b64d_out_t  m_data
);

    // A stalled input transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("stalled input changed");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // An error result is final and carries no byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.last && !m_data.byte_valid)
        else $error("error result malformed");

    // A result without a byte shows a zero byte and ends the text.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid |-> m_data.data_byte == 8'h00 && m_data.last)
        else $error("empty result malformed");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
